[sv/fqsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsp_pkg
// Shared types, character constants and the hex digit decoder for the
// form query string parser.
// ----------------------------------------------------------------------------
package fqsp_pkg;

  // Escape sequence progress
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CH_NL      = 8'h0A;  // newline
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_EQ      = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [7:0] CH_0       = 8'h30;  // '0'
  localparam logic [7:0] CH_9       = 8'h39;  // '9'
  localparam logic [7:0] CH_A       = 8'h41;  // 'A'
  localparam logic [7:0] CH_F       = 8'h46;  // 'F'

  typedef struct packed {
    logic [1:0] escape_phase;
    logic [3:0] high_nibble;
    logic       in_value_part;
    logic       field_open;
    logic       any_field_seen;
    logic       error_seen;
  } fqsp_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_value;
    logic       byte_valid;
    logic       field_end;
    logic       list_end;
    logic       error;
  } fqsp_result_t;

  // Uppercase hex digit: bit 4 set when the byte is a digit, bits 3:0 its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    begin
      d = 8'd0;
      hex_digit = 5'd0;
      if (b >= CH_0 && b <= CH_9) begin
        d = b - CH_0;
        hex_digit = {1'b1, d[3:0]};
      end else if (b >= CH_A && b <= CH_F) begin
        d = b - CH_A + 8'd10;
        hex_digit = {1'b1, d[3:0]};
      end
    end
  endfunction

endpackage

[sv/fqsp_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsp_decode
// Next-state and result logic for one raw byte of the query string.
// ----------------------------------------------------------------------------
module fqsp_decode (
  input  logic [7:0]            in_byte,
  input  logic                  last,
  input  fqsp_pkg::fqsp_state_t cur,
  output fqsp_pkg::fqsp_state_t nxt,
  output fqsp_pkg::fqsp_result_t res,
  output logic                  emit
);
  import fqsp_pkg::*;

  logic       is_delim;
  logic [4:0] dig;
  logic       have_dec;
  logic [7:0] dec;
  logic       have_data;
  logic [7:0] data;
  logic       data_is_value;
  logic       closed;
  logic       err;
  logic       valid;

  assign is_delim = (in_byte == CH_AMP) || (in_byte == CH_NL);
  assign dig      = hex_digit(in_byte);

  always_comb begin
    nxt           = cur;
    have_dec      = 1'b0;
    dec           = 8'd0;
    have_data     = 1'b0;
    data          = 8'd0;
    data_is_value = 1'b0;
    closed        = 1'b0;
    err           = cur.error_seen;

    if (is_delim) begin
      if (cur.field_open) begin
        if (cur.escape_phase == ESC_HIGH || cur.escape_phase == ESC_LOW) begin
          err = 1'b1;
        end
        if (!cur.in_value_part) begin
          err = 1'b1;
        end
        closed = 1'b1;
      end
      nxt.field_open    = 1'b0;
      nxt.in_value_part = 1'b0;
      nxt.escape_phase  = ESC_NONE;
    end else begin
      nxt.field_open     = 1'b1;
      nxt.any_field_seen = 1'b1;
      unique case (cur.escape_phase)
        ESC_HIGH: begin
          if (!dig[4]) begin
            err              = 1'b1;
            nxt.escape_phase = ESC_NONE;
          end else begin
            nxt.high_nibble  = dig[3:0];
            nxt.escape_phase = ESC_LOW;
          end
        end
        ESC_LOW: begin
          nxt.escape_phase = ESC_NONE;
          if (!dig[4]) begin
            err = 1'b1;
          end else begin
            dec      = {cur.high_nibble, dig[3:0]};
            have_dec = 1'b1;
          end
        end
        default: begin
          nxt.escape_phase = ESC_NONE;
          if (in_byte == CH_PERCENT) begin
            nxt.escape_phase = ESC_HIGH;
          end else if (in_byte == CH_PLUS) begin
            dec      = CH_SPACE;
            have_dec = 1'b1;
          end else begin
            dec      = in_byte;
            have_dec = 1'b1;
          end
        end
      endcase
    end

    // First decoded '=' switches from name to value
    if (have_dec) begin
      if (!nxt.in_value_part && dec == CH_EQ) begin
        nxt.in_value_part = 1'b1;
      end else begin
        have_data     = 1'b1;
        data          = dec;
        data_is_value = nxt.in_value_part;
      end
    end

    if (last) begin
      if (nxt.escape_phase == ESC_HIGH || nxt.escape_phase == ESC_LOW) begin
        err = 1'b1;
      end
      if (nxt.field_open) begin
        if (!nxt.in_value_part) begin
          err = 1'b1;
        end
        closed = 1'b1;
      end
      if (!nxt.any_field_seen) begin
        err = 1'b1;
      end
    end

    nxt.error_seen = err;

    // End of string: start over
    if (last) begin
      nxt.escape_phase   = ESC_NONE;
      nxt.in_value_part  = 1'b0;
      nxt.field_open     = 1'b0;
      nxt.any_field_seen = 1'b0;
      nxt.error_seen     = 1'b0;
    end
  end

  assign valid          = have_data && !err;
  assign emit           = last || (!err && (have_data || closed));
  assign res.out_byte   = valid ? data : 8'd0;
  assign res.is_value   = valid ? data_is_value : 1'b0;
  assign res.byte_valid = valid;
  assign res.field_end  = closed;
  assign res.list_end   = last;
  assign res.error      = err;

endmodule

[sv/fqsp_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsp_out_stage
// Result register: hold a beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module fqsp_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  fqsp_pkg::fqsp_result_t din,
  input  logic                   take,
  output logic                   valid,
  output fqsp_pkg::fqsp_result_t dout
);
  import fqsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

[sv/form_query_string_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_query_string_parser
// Decodes an urlencoded form query string into name and value bytes.
// ----------------------------------------------------------------------------
// Output: a result, when a byte produces one, appears on the master side in the cycle after that byte is taken.
// Throughput: one byte per cycle unless a held result stalls the input; the parse state updates
//   with each accepted byte and the result register frees as soon as downstream takes its beat.
// Reset (rst, synchronous, active high): escape, field and error state clear,
//   the result register empties.
module form_query_string_parser (
  input  logic        clk,
  input  logic        rst,
  // Input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last
  // Decoded results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] field_end, rest zero
  output logic [2:0]  m_axis_tuser,   // [0] is_value, [1] byte_valid, [2] error
  output logic        m_axis_tlast    // list_end
);
  import fqsp_pkg::*;

  fqsp_state_t  state;
  fqsp_state_t  state_next;
  fqsp_result_t res;
  fqsp_result_t held;
  logic         emit;
  logic         accept;
  logic         out_valid;

  // Take a new beat whenever the result register is empty or being drained
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fqsp_decode u_decode (
    .in_byte (s_axis_tdata),
    .last    (s_axis_tlast),
    .cur     (state),
    .nxt     (state_next),
    .res     (res),
    .emit    (emit)
  );

  // Control state clears on reset; the held nibble is payload and is always
  // written before it is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.escape_phase   <= ESC_NONE;
      state.in_value_part  <= 1'b0;
      state.field_open     <= 1'b0;
      state.any_field_seen <= 1'b0;
      state.error_seen     <= 1'b0;
    end else if (accept) begin
      state.escape_phase   <= state_next.escape_phase;
      state.in_value_part  <= state_next.in_value_part;
      state.field_open     <= state_next.field_open;
      state.any_field_seen <= state_next.any_field_seen;
      state.error_seen     <= state_next.error_seen;
    end
    if (accept) begin
      state.high_nibble <= state_next.high_nibble;
    end
  end

  // Drop bytes that produce nothing; register the rest
  fqsp_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (accept && emit),
    .din   (res),
    .take  (m_axis_tready),
    .valid (out_valid),
    .dout  (held)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, held.field_end, held.out_byte};
  assign m_axis_tuser  = {held.error, held.byte_valid, held.is_value};
  assign m_axis_tlast  = held.list_end;

`ifndef SYNTHESIS
  // The final byte of a string leaves the parser ready for a fresh one
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (state.escape_phase == ESC_NONE && !state.field_open
                                  && !state.in_value_part && !state.error_seen))
    else $error("parse state not cleared after final byte");

  // An error is only ever reported on the final result
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tlast)
    else $error("error reported before end of list");

  // A data byte is never delivered with the error flag
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[2])
    else $error("data byte delivered with error set");
`endif

endmodule

[tb/form_query_string_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_query_string_parser_test
// Self-checking bench for the form query string parser. It feeds directed
// strings, then random well-formed, broken and noise strings, with random gaps
// on both sides and one long output stall. Every byte taken by the block is
// run through a bit-exact decoder model. Every result beat is compared against
// the oldest predicted result.
// ----------------------------------------------------------------------------
module form_query_string_parser_test;
  import fqsp_pkg::*;

  localparam int RANDOM_BYTES = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;

  // Decoder model plus the queue of results it predicts.
  class decode_scoreboard;
    localparam int MAX_REPORTS = 10;

    logic [1:0]   esc;
    logic [3:0]   hi;
    logic         in_val;
    logic         fld_open;
    logic         any_fld;
    logic         err;
    fqsp_result_t expected_q[$];
    int           mismatches;

    function new();
      clear_string();
      mismatches = 0;
    endfunction

    function void clear_string();
      esc      = ESC_NONE;
      hi       = 4'd0;
      in_val   = 1'b0;
      fld_open = 1'b0;
      any_fld  = 1'b0;
      err      = 1'b0;
    endfunction

    // Uppercase hex digit value, -1 for anything else.
    function int hex_value(logic [7:0] b);
      if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
      if (b >= CH_A && b <= CH_F) return int'(b - CH_A) + 10;
      return -1;
    endfunction

    // Advance the model by one accepted input beat.
    function void note_byte(logic [7:0] b, logic lst);
      logic         have_dec;
      logic         have_data;
      logic         closed;
      logic         data_val;
      logic [7:0]   dec;
      logic [7:0]   data;
      int           nib;
      fqsp_result_t r;
      have_dec  = 1'b0;
      have_data = 1'b0;
      closed    = 1'b0;
      data_val  = 1'b0;
      dec       = 8'd0;
      data      = 8'd0;
      nib       = hex_value(b);
      if (b == CH_AMP || b == CH_NL) begin
        if (fld_open) begin
          if (esc == ESC_HIGH || esc == ESC_LOW || !in_val) err = 1'b1;
          closed = 1'b1;
        end
        fld_open = 1'b0;
        in_val   = 1'b0;
        esc      = ESC_NONE;
      end else begin
        fld_open = 1'b1;
        any_fld  = 1'b1;
        if (esc == ESC_HIGH) begin
          if (nib < 0) begin
            err = 1'b1;
            esc = ESC_NONE;
          end else begin
            hi  = nib[3:0];
            esc = ESC_LOW;
          end
        end else if (esc == ESC_LOW) begin
          esc = ESC_NONE;
          if (nib < 0) begin
            err = 1'b1;
          end else begin
            dec      = {hi, nib[3:0]};
            have_dec = 1'b1;
          end
        end else begin
          esc = ESC_NONE;
          if (b == CH_PERCENT) begin
            esc = ESC_HIGH;
          end else begin
            dec      = (b == CH_PLUS) ? CH_SPACE : b;
            have_dec = 1'b1;
          end
        end
      end
      // The first decoded '=' of a field switches from name to value.
      if (have_dec) begin
        if (!in_val && dec == CH_EQ) begin
          in_val = 1'b1;
        end else begin
          have_data = 1'b1;
          data      = dec;
          data_val  = in_val;
        end
      end
      if (lst) begin
        if (esc == ESC_HIGH || esc == ESC_LOW) err = 1'b1;
        if (fld_open) begin
          if (!in_val) err = 1'b1;
          closed = 1'b1;
        end
        if (!any_fld) err = 1'b1;
      end
      if (lst || (!err && (have_data || closed))) begin
        r.byte_valid = have_data && !err;
        r.out_byte   = r.byte_valid ? data : 8'd0;
        r.is_value   = r.byte_valid ? data_val : 1'b0;
        r.field_end  = closed;
        r.list_end   = lst;
        r.error      = err;
        expected_q.push_back(r);
      end
      if (lst) clear_string();
    endfunction

    // Compare one accepted output beat with the oldest prediction.
    function void check_result(logic [15:0] tdata, logic [2:0] tuser, logic tlast);
      fqsp_result_t got;
      fqsp_result_t want;
      got.out_byte   = tdata[7:0];
      got.field_end  = tdata[8];
      got.is_value   = tuser[0];
      got.byte_valid = tuser[1];
      got.error      = tuser[2];
      got.list_end   = tlast;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected beat byte=%h val=%b bv=%b fe=%b le=%b err=%b",
                   got.out_byte, got.is_value, got.byte_valid, got.field_end,
                   got.list_end, got.error);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want || tdata[15:9] !== 7'd0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"ERROR: exp byte=%h val=%b bv=%b fe=%b le=%b err=%b",
                    " | got byte=%h val=%b bv=%b fe=%b le=%b err=%b pad=%h"},
                   want.out_byte, want.is_value, want.byte_valid, want.field_end,
                   want.list_end, want.error, got.out_byte, got.is_value,
                   got.byte_valid, got.field_end, got.list_end, got.error,
                   tdata[15:9]);
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] field_end
  logic [2:0]  m_axis_tuser;           // [0] is_value, [1] byte_valid, [2] error
  logic        m_axis_tlast;           // list_end

  decode_scoreboard sb;
  logic [7:0]       text[$];           // raw bytes of the next string
  bit               tx_burst    = 1'b0;
  bit               rx_hold_req = 1'b0;
  int               bytes_sent  = 0;
  int               idle_cycles = 0;

  form_query_string_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Sample both handshakes at the edge; check results before noting the
  // new input so a beat never meets its own prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // Watchdog: too many cycles without any beat ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? CH_0 + 8'(n) : CH_A + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] delim();
    return $urandom_range(0, 1) ? CH_AMP : CH_NL;
  endfunction

  // Append one decoded character, raw, as '+' or as an escape.
  function automatic void add_char(bit allow_eq);
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: text.push_back(CH_PLUS);
      1, 2: begin
        c = 8'($urandom_range(0, 255));
        // Now and then escape a delimiter or '='
        if ($urandom_range(0, 3) == 0)
          c = ($urandom_range(0, 2) == 0) ? CH_AMP : ($urandom_range(0, 1) ? CH_NL : CH_EQ);
        text.push_back(CH_PERCENT);
        text.push_back(hex_char(c[7:4]));
        text.push_back(hex_char(c[3:0]));
      end
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_AMP || c == CH_NL || c == CH_PERCENT || c == CH_PLUS ||
               (!allow_eq && c == CH_EQ));
        text.push_back(c);
      end
    endcase
  endfunction

  // Drive the current string, one beat per byte, last on the final one.
  task automatic send_text();
    int gap;
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= text[i];
      s_axis_tlast  <= (i == text.size() - 1);
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      bytes_sent++;
    end
  endtask

  // Receiver: random stall before each beat, bursts with none, and one long
  // hold on request so the block backs up into its input.
  initial begin : receiver
    int stall;
    bit rx_burst;
    rx_burst = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall       = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int  kind;
    int  pos;
    int  fields;
    int  directed;
    bit  held;
    held = 1'b0;
    sb   = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Escaped '=' ends an empty name, escaped '&' is data, '+', zero and
    // all-ones bytes, newline split, then a field whose value is "=".
    text = '{CH_PERCENT, "3", "D", CH_PERCENT, "2", "6", CH_EQ, CH_PLUS,
             8'h00, 8'hFF, CH_NL, CH_EQ, CH_EQ};
    send_text();
    // Lowercase hex digit in an escape
    text = '{CH_PERCENT, "4", "a"};
    send_text();
    // Field closed by a delimiter without any '='
    text = '{"a", CH_AMP};
    send_text();
    // Nothing but a delimiter: no field at all
    text = '{CH_AMP};
    send_text();
    // Escape cut short by the end of the string
    text = '{"b", CH_EQ, CH_PERCENT, "F"};
    send_text();
    // Lone '%' cut short by a delimiter
    text = '{CH_EQ, CH_PERCENT, CH_AMP};
    send_text();
    directed = bytes_sent;

    while (bytes_sent < directed + RANDOM_BYTES) begin
      if (!held && bytes_sent > directed + 600) begin
        rx_hold_req = 1'b1;
        held        = 1'b1;
      end
      kind = $urandom_range(0, 9);
      text.delete();
      if (kind == 0) begin
        // Noise: arbitrary bytes
        repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        // Well-formed list of name=value fields, with occasional empty fields
        fields = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) text.push_back(delim());
        for (int f = 0; f < fields; f++) begin
          if (f > 0) begin
            text.push_back(delim());
            if ($urandom_range(0, 7) == 0) text.push_back(delim());
          end
          repeat ($urandom_range(0, 4)) add_char(1'b0);
          if ($urandom_range(0, 5) == 0) begin
            text.push_back(CH_PERCENT);
            text.push_back(hex_char(4'h3));
            text.push_back(hex_char(4'hD));
          end else begin
            text.push_back(CH_EQ);
          end
          repeat ($urandom_range(0, 5)) add_char(1'b1);
        end
        if ($urandom_range(0, 7) == 0) text.push_back(delim());
        // Break a few of them: insert, drop, truncate or overwrite a byte
        if (kind < 3) begin
          pos = $urandom_range(0, text.size() - 1);
          case ($urandom_range(0, 3))
            0: text.insert(pos, 8'($urandom_range(0, 255)));
            1: if (text.size() > 1) text.delete(pos);
            2: while (text.size() > pos + 1) void'(text.pop_back());
            default: text[pos] = 8'($urandom_range(0, 255));
          endcase
        end
      end
      send_text();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then wait briefly for any stray beats to show up
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
